FILE: src/mfp_pkg.sv
// Shared types, codes and helper functions of the MIDI file track parser.
`timescale 1ns / 1ps

package mfp_pkg;

  localparam logic [2:0] KIND_MIDI  = 3'd0;
  localparam logic [2:0] KIND_DELTA = 3'd1;
  localparam logic [2:0] KIND_TEMPO = 3'd2;
  localparam logic [2:0] KIND_END   = 3'd3;
  localparam logic [2:0] KIND_ERROR = 3'd4;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_NO_STATUS = 3'd1;
  localparam logic [2:0] ERR_BAD_TYPE  = 3'd2;
  localparam logic [2:0] ERR_VARLEN    = 3'd3;
  localparam logic [2:0] ERR_TRUNC     = 3'd4;

  localparam logic [7:0] BYTE_SYSEX   = 8'hF0;
  localparam logic [7:0] BYTE_RAW     = 8'hF7;
  localparam logic [7:0] BYTE_META    = 8'hFF;
  localparam logic [7:0] META_EOT     = 8'h2F;
  localparam logic [7:0] META_TEMPO   = 8'h51;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [27:0] value;
    logic [2:0]  err;
  } res_t;

  // All results caused by one input byte.
  typedef struct packed {
    logic [1:0]     cnt;
    res_t [2:0]     slot;
  } bundle_t;

  // Number of data bytes of a voice message, by status bits 6:4.
  function automatic logic [1:0] voice_data_len(input logic [2:0] hi);
    logic [1:0] len;
    unique case (hi)
      3'd4, 3'd5: len = 2'd1;
      3'd7:       len = 2'd0;
      default:    len = 2'd2;
    endcase
    return len;
  endfunction

  function automatic res_t mk_res(input logic [2:0] kind, input logic [27:0] value,
                                  input logic [2:0] err);
    res_t r;
    r.kind  = kind;
    r.value = value;
    r.err   = err;
    return r;
  endfunction

endpackage

FILE: src/mfp_front.sv
// Front end: byte parser state machine, one result bundle per accepted byte that yields results.
`timescale 1ns / 1ps

module mfp_front #(
  parameter int VARLEN_MAX_BYTES = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [31:0]          cfg_len,
  input  logic                 push,
  input  logic [7:0]           data_byte,
  input  logic                 q_full,
  output logic                 q_push,
  output mfp_pkg::bundle_t     q_data
);

  localparam int VB_W = $clog2(VARLEN_MAX_BYTES + 1);

  typedef enum logic [11:0] {
    PH_DELTA     = 12'b0000_0000_0001,
    PH_EVENT     = 12'b0000_0000_0010,
    PH_META_TYPE = 12'b0000_0000_0100,
    PH_META_LEN  = 12'b0000_0000_1000,
    PH_META_SKIP = 12'b0000_0001_0000,
    PH_TEMPO     = 12'b0000_0010_0000,
    PH_SYSEX_LEN = 12'b0000_0100_0000,
    PH_RAW_LEN   = 12'b0000_1000_0000,
    PH_FORWARD   = 12'b0001_0000_0000,
    PH_VOICE_D1  = 12'b0010_0000_0000,
    PH_VOICE_D2  = 12'b0100_0000_0000,
    PH_DONE      = 12'b1000_0000_0000
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  running_status, running_status_next;
  logic [27:0] varlen_accum, varlen_accum_next;
  logic [VB_W-1:0] varlen_bytes, varlen_bytes_next;
  logic [31:0] chunk_left, chunk_left_next;
  logic [27:0] event_left, event_left_next;
  logic [23:0] tempo_accum, tempo_accum_next;
  logic [1:0]  tempo_bytes, tempo_bytes_next;
  logic [7:0]  meta_kind, meta_kind_next;

  logic            active, complete, do_voice;
  logic [2:0]      err;
  logic [1:0]      n;
  logic [31:0]     left_dec;
  logic [27:0]     vl_acc;
  logic [VB_W-1:0] vl_inc;
  logic            vl_long;
  mfp_pkg::bundle_t bnd;

  always_comb begin
    phase_next          = phase;
    running_status_next = running_status;
    varlen_accum_next   = varlen_accum;
    varlen_bytes_next   = varlen_bytes;
    chunk_left_next     = chunk_left;
    event_left_next     = event_left;
    tempo_accum_next    = tempo_accum;
    tempo_bytes_next    = tempo_bytes;
    meta_kind_next      = meta_kind;
    bnd       = '0;
    n         = 2'd0;
    err       = mfp_pkg::ERR_NONE;
    complete  = 1'b0;
    do_voice  = 1'b0;
    left_dec  = chunk_left - 32'd1;
    vl_acc    = {varlen_accum[20:0], data_byte[6:0]};
    vl_inc    = varlen_bytes + VB_W'(1);
    vl_long   = data_byte[7] && (32'(vl_inc) >= 32'(VARLEN_MAX_BYTES));
    active    = push && !q_full && (phase != PH_DONE) && (chunk_left != 32'd0);

    if (active) begin
      chunk_left_next = left_dec;
      unique case (phase)
        PH_DELTA: begin
          varlen_accum_next = vl_acc;
          if (!data_byte[7]) begin
            bnd.slot[n] = mfp_pkg::mk_res(mfp_pkg::KIND_DELTA, vl_acc, mfp_pkg::ERR_NONE);
            n = n + 2'd1;
            varlen_accum_next = '0;
            varlen_bytes_next = '0;
            phase_next = PH_EVENT;
          end else begin
            varlen_bytes_next = vl_inc;
            if (vl_long) err = mfp_pkg::ERR_VARLEN;
          end
        end
        PH_EVENT: begin
          if (data_byte == mfp_pkg::BYTE_META) begin
            phase_next = PH_META_TYPE;
          end else if (data_byte == mfp_pkg::BYTE_RAW) begin
            varlen_accum_next = '0;
            varlen_bytes_next = '0;
            phase_next = PH_RAW_LEN;
          end else if (data_byte == mfp_pkg::BYTE_SYSEX) begin
            varlen_accum_next = '0;
            varlen_bytes_next = '0;
            phase_next = PH_SYSEX_LEN;
          end else if (data_byte < mfp_pkg::BYTE_SYSEX) begin
            if (data_byte[7]) begin
              running_status_next = data_byte;
              phase_next = PH_VOICE_D1;
            end else if (running_status == 8'd0) begin
              err = mfp_pkg::ERR_NO_STATUS;
            end else begin
              do_voice = 1'b1;
            end
          end else begin
            err = mfp_pkg::ERR_BAD_TYPE;
          end
        end
        PH_VOICE_D1: do_voice = 1'b1;
        PH_VOICE_D2: begin
          bnd.slot[n] = mfp_pkg::mk_res(mfp_pkg::KIND_MIDI, {20'd0, data_byte},
                                        mfp_pkg::ERR_NONE);
          n = n + 2'd1;
          complete = 1'b1;
        end
        PH_META_TYPE: begin
          meta_kind_next    = data_byte;
          varlen_accum_next = '0;
          varlen_bytes_next = '0;
          phase_next        = PH_META_LEN;
        end
        PH_META_LEN: begin
          varlen_accum_next = vl_acc;
          if (data_byte[7]) begin
            varlen_bytes_next = vl_inc;
            if (vl_long) err = mfp_pkg::ERR_VARLEN;
          end else begin
            running_status_next = 8'd0;
            if (meta_kind == mfp_pkg::META_EOT) begin
              bnd.slot[n] = mfp_pkg::mk_res(mfp_pkg::KIND_END, 28'd0, mfp_pkg::ERR_NONE);
              n = n + 2'd1;
              phase_next = PH_DONE;
            end else if (meta_kind == mfp_pkg::META_TEMPO) begin
              if (left_dec < 32'd3) begin
                err = mfp_pkg::ERR_TRUNC;
              end else begin
                tempo_accum_next = '0;
                tempo_bytes_next = '0;
                phase_next       = PH_TEMPO;
              end
            end else if ({4'd0, vl_acc} > left_dec) begin
              err = mfp_pkg::ERR_TRUNC;
            end else if (vl_acc == 28'd0) begin
              complete = 1'b1;
            end else begin
              event_left_next = vl_acc;
              phase_next      = PH_META_SKIP;
            end
          end
        end
        PH_META_SKIP: begin
          event_left_next = event_left - 28'd1;
          if (event_left == 28'd1) complete = 1'b1;
        end
        PH_TEMPO: begin
          tempo_accum_next = {tempo_accum[15:0], data_byte};
          if (tempo_bytes >= 2'd2) begin
            bnd.slot[n] = mfp_pkg::mk_res(mfp_pkg::KIND_TEMPO, {4'd0, tempo_accum_next},
                                          mfp_pkg::ERR_NONE);
            n = n + 2'd1;
            complete = 1'b1;
          end else begin
            tempo_bytes_next = tempo_bytes + 2'd1;
          end
        end
        PH_SYSEX_LEN, PH_RAW_LEN: begin
          varlen_accum_next = vl_acc;
          if (data_byte[7]) begin
            varlen_bytes_next = vl_inc;
            if (vl_long) err = mfp_pkg::ERR_VARLEN;
          end else begin
            running_status_next = 8'd0;
            if (phase == PH_SYSEX_LEN) begin
              bnd.slot[n] = mfp_pkg::mk_res(mfp_pkg::KIND_MIDI, {20'd0, mfp_pkg::BYTE_SYSEX},
                                            mfp_pkg::ERR_NONE);
              n = n + 2'd1;
            end
            if ({4'd0, vl_acc} > left_dec) begin
              err = mfp_pkg::ERR_TRUNC;
            end else if (vl_acc == 28'd0) begin
              complete = 1'b1;
            end else begin
              event_left_next = vl_acc;
              phase_next      = PH_FORWARD;
            end
          end
        end
        PH_FORWARD: begin
          bnd.slot[n] = mfp_pkg::mk_res(mfp_pkg::KIND_MIDI, {20'd0, data_byte},
                                        mfp_pkg::ERR_NONE);
          n = n + 2'd1;
          event_left_next = event_left - 28'd1;
          if (event_left == 28'd1) complete = 1'b1;
        end
        default: phase_next = PH_DONE;
      endcase

      if (do_voice) begin
        bnd.slot[n] = mfp_pkg::mk_res(mfp_pkg::KIND_MIDI, {20'd0, running_status_next},
                                      mfp_pkg::ERR_NONE);
        n = n + 2'd1;
        bnd.slot[n] = mfp_pkg::mk_res(mfp_pkg::KIND_MIDI, {20'd0, data_byte},
                                      mfp_pkg::ERR_NONE);
        n = n + 2'd1;
        if (mfp_pkg::voice_data_len(running_status_next[6:4]) == 2'd2)
          phase_next = PH_VOICE_D2;
        else
          complete = 1'b1;
      end

      priority if (err != mfp_pkg::ERR_NONE) begin
        bnd.slot[n] = mfp_pkg::mk_res(mfp_pkg::KIND_ERROR, 28'd0, err);
        n = n + 2'd1;
        phase_next = PH_DONE;
      end else if (complete) begin
        varlen_accum_next = '0;
        varlen_bytes_next = '0;
        if (left_dec == 32'd0) begin
          bnd.slot[n] = mfp_pkg::mk_res(mfp_pkg::KIND_END, 28'd0, mfp_pkg::ERR_NONE);
          n = n + 2'd1;
          phase_next = PH_DONE;
        end else begin
          phase_next = PH_DELTA;
        end
      end else if (phase_next != PH_DONE && left_dec == 32'd0) begin
        bnd.slot[n] = mfp_pkg::mk_res(mfp_pkg::KIND_ERROR, 28'd0, mfp_pkg::ERR_TRUNC);
        n = n + 2'd1;
        phase_next = PH_DONE;
      end else begin
        phase_next = phase_next;
      end
    end
    bnd.cnt = n;
  end

  assign q_push = active && (n != 2'd0);
  assign q_data = bnd;

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      phase          <= PH_DELTA;
      running_status <= '0;
      varlen_accum   <= '0;
      varlen_bytes   <= '0;
      chunk_left     <= rst ? 32'd0 : cfg_len;
      event_left     <= '0;
      tempo_accum    <= '0;
      tempo_bytes    <= '0;
      meta_kind      <= '0;
    end else begin
      phase          <= phase_next;
      running_status <= running_status_next;
      varlen_accum   <= varlen_accum_next;
      varlen_bytes   <= varlen_bytes_next;
      chunk_left     <= chunk_left_next;
      event_left     <= event_left_next;
      tempo_accum    <= tempo_accum_next;
      tempo_bytes    <= tempo_bytes_next;
      meta_kind      <= meta_kind_next;
    end
  end

endmodule

FILE: src/mfp_queue.sv
// Short bundle queue between the parser and the result sequencer.
`timescale 1ns / 1ps

module mfp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mfp_pkg::bundle_t wdata,
  output logic             full,
  input  logic             pop,
  output mfp_pkg::bundle_t rdata,
  output logic             empty
);

  localparam int PW = $clog2(mfp_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(mfp_pkg::QUEUE_DEPTH + 1);

  mfp_pkg::bundle_t mem [mfp_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full    = (32'(count) == 32'(mfp_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + PW'(1);
      if (do_pop) rptr <= rptr + PW'(1);
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/mfp_back.sv
// Back end: hands out the results of each bundle one transaction at a time.
`timescale 1ns / 1ps

module mfp_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  mfp_pkg::bundle_t q_data,
  output logic             q_pop,
  input  logic             pop,
  output logic             empty,
  output logic [2:0]       result_kind,
  output logic [27:0]      result_value,
  output logic [2:0]       error_code,
  output logic             last_of_run
);

  mfp_pkg::bundle_t cur;
  logic             cur_valid;
  logic [1:0]       idx;
  logic             take, finish;
  mfp_pkg::res_t    r;

  assign r            = cur.slot[idx];
  assign last_of_run  = (idx == cur.cnt - 2'd1);
  assign empty        = !cur_valid;
  assign take         = cur_valid && pop;
  assign finish       = take && last_of_run;
  assign q_pop        = (!cur_valid || finish) && !q_empty;
  assign result_kind  = r.kind;
  assign result_value = r.value;
  assign error_code   = r.err;

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else begin
      priority if (q_pop) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (finish) begin
        cur_valid <= 1'b0;
        idx       <= '0;
      end else if (take) begin
        idx <= idx + 2'd1;
      end else begin
        idx <= idx;
      end
    end
  end

endmodule

FILE: src/midi_file_track_event_parser_core.sv
// Top level of the MIDI file track parser: parser, bundle queue, result sequencer.
//
//   channel  direction  handshake             payload
//   input    in         push / full           data_byte
//   config   in         cfg_valid / cfg_ready track_length
//   result   out        empty / pop           result_kind, result_value, error_code,
//                                             last_of_run
//
// One byte is parsed per cycle while full is low; it yields zero to three results,
// which leave one per cycle while pop is held.
// A four-entry bundle queue decouples the parser from the result port.
// Synchronous reset clears all state; track_length 0 ignores every byte.
// full rises only when the bundle queue is full; a track_length write restarts parsing.
`timescale 1ns / 1ps

module midi_file_track_event_parser_core #(
  parameter int VARLEN_MAX_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] track_length,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  result_kind,
  output logic [27:0] result_value,
  output logic [2:0]  error_code,
  output logic        last_of_run
);

  mfp_pkg::bundle_t f_data, b_data;
  logic             f_push, q_full, q_empty, b_pop;

  assign cfg_ready = 1'b1;
  assign full      = q_full;

  mfp_front #(
    .VARLEN_MAX_BYTES(VARLEN_MAX_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_len  (track_length),
    .push     (push),
    .data_byte(data_byte),
    .q_full   (q_full),
    .q_push   (f_push),
    .q_data   (f_data)
  );

  mfp_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (f_push),
    .wdata(f_data),
    .full (q_full),
    .pop  (b_pop),
    .rdata(b_data),
    .empty(q_empty)
  );

  mfp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_data      (b_data),
    .q_pop       (b_pop),
    .pop         (pop),
    .empty       (empty),
    .result_kind (result_kind),
    .result_value(result_value),
    .error_code  (error_code),
    .last_of_run (last_of_run)
  );

endmodule

FILE: bench/midi_file_track_event_parser_core_test.sv
// Self-checking testbench for the MIDI file track parser core: random tracks and a scoreboard.
`timescale 1ns / 1ps

module midi_file_track_event_parser_core_test;

  localparam int VARLEN_LIMIT = 4;
  localparam int DRAIN_CYCLES = 16;

  typedef enum logic [11:0] {
    ST_DELTA     = 12'b0000_0000_0001,
    ST_EVENT     = 12'b0000_0000_0010,
    ST_META_TYPE = 12'b0000_0000_0100,
    ST_META_LEN  = 12'b0000_0000_1000,
    ST_META_SKIP = 12'b0000_0001_0000,
    ST_TEMPO     = 12'b0000_0010_0000,
    ST_SYSEX_LEN = 12'b0000_0100_0000,
    ST_RAW_LEN   = 12'b0000_1000_0000,
    ST_FORWARD   = 12'b0001_0000_0000,
    ST_DATA1     = 12'b0010_0000_0000,
    ST_DATA2     = 12'b0100_0000_0000,
    ST_DONE      = 12'b1000_0000_0000
  } parse_state_t;

  typedef enum {VL_MORE, VL_DONE, VL_LONG} varlen_t;

  typedef struct {
    logic [2:0]  kind;
    logic [27:0] value;
    logic [2:0]  err;
    logic        last;
  } parsed_result_t;

  class track_scoreboard;
    parsed_result_t expected_q[$];
    int             failures;
    parse_state_t   state;
    logic [7:0]     status;
    logic [27:0]    accum;
    logic [2:0]     vl_count;
    logic [31:0]    chunk_left;
    logic [27:0]    event_left;
    logic [23:0]    tempo;
    logic [1:0]     tempo_count;
    logic [7:0]     meta_id;

    function void restart_track(logic [31:0] len);
      state       = ST_DELTA;
      status      = 8'h00;
      accum       = '0;
      vl_count    = '0;
      chunk_left  = len;
      event_left  = '0;
      tempo       = '0;
      tempo_count = '0;
      meta_id     = 8'h00;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void queue_result(logic [2:0] k, logic [27:0] v, logic [2:0] e);
      parsed_result_t r;
      r.kind  = k;
      r.value = v;
      r.err   = e;
      r.last  = 1'b0;
      expected_q.push_back(r);
    endfunction

    function varlen_t take_varlen(logic [7:0] c);
      accum = {accum[20:0], c[6:0]};
      if (!c[7]) return VL_DONE;
      vl_count++;
      if (vl_count >= VARLEN_LIMIT) return VL_LONG;
      return VL_MORE;
    endfunction

    // Emits status and first data byte; returns 1 when the message is complete.
    function bit voice_data(logic [7:0] c);
      queue_result(mfp_pkg::KIND_MIDI, {20'd0, status}, mfp_pkg::ERR_NONE);
      queue_result(mfp_pkg::KIND_MIDI, {20'd0, c}, mfp_pkg::ERR_NONE);
      if (status[6:4] == 3'd4 || status[6:4] == 3'd5 || status[6:4] == 3'd7) return 1'b1;
      state = ST_DATA2;
      return 1'b0;
    endfunction

    function void note_byte(logic [7:0] c);
      logic [2:0] err;
      bit         complete;
      varlen_t    v;
      int         first;
      err      = mfp_pkg::ERR_NONE;
      complete = 1'b0;
      first    = expected_q.size();
      if (state == ST_DONE || chunk_left == 0) return;
      chunk_left--;
      unique case (state)
        ST_DELTA: begin
          v = take_varlen(c);
          if (v == VL_LONG) begin
            err = mfp_pkg::ERR_VARLEN;
          end else if (v == VL_DONE) begin
            queue_result(mfp_pkg::KIND_DELTA, accum, mfp_pkg::ERR_NONE);
            accum    = '0;
            vl_count = '0;
            state    = ST_EVENT;
          end
        end
        ST_EVENT: begin
          if (c == mfp_pkg::BYTE_META) begin
            state = ST_META_TYPE;
          end else if (c == mfp_pkg::BYTE_RAW) begin
            accum    = '0;
            vl_count = '0;
            state    = ST_RAW_LEN;
          end else if (c == mfp_pkg::BYTE_SYSEX) begin
            accum    = '0;
            vl_count = '0;
            state    = ST_SYSEX_LEN;
          end else if (c < mfp_pkg::BYTE_SYSEX) begin
            if (c[7]) begin
              status = c;
              state  = ST_DATA1;
            end else if (status == 8'h00) begin
              err = mfp_pkg::ERR_NO_STATUS;
            end else begin
              state    = ST_DATA1;
              complete = voice_data(c);
            end
          end else begin
            err = mfp_pkg::ERR_BAD_TYPE;
          end
        end
        ST_DATA1: complete = voice_data(c);
        ST_DATA2: begin
          queue_result(mfp_pkg::KIND_MIDI, {20'd0, c}, mfp_pkg::ERR_NONE);
          complete = 1'b1;
        end
        ST_META_TYPE: begin
          meta_id  = c;
          accum    = '0;
          vl_count = '0;
          state    = ST_META_LEN;
        end
        ST_META_LEN: begin
          v = take_varlen(c);
          if (v == VL_LONG) begin
            err = mfp_pkg::ERR_VARLEN;
          end else if (v == VL_DONE) begin
            status = 8'h00;
            if (meta_id == mfp_pkg::META_EOT) begin
              queue_result(mfp_pkg::KIND_END, '0, mfp_pkg::ERR_NONE);
              state = ST_DONE;
            end else if (meta_id == mfp_pkg::META_TEMPO) begin
              if (chunk_left < 3) begin
                err = mfp_pkg::ERR_TRUNC;
              end else begin
                tempo       = '0;
                tempo_count = '0;
                state       = ST_TEMPO;
              end
            end else if ({4'd0, accum} > chunk_left) begin
              err = mfp_pkg::ERR_TRUNC;
            end else if (accum == 0) begin
              complete = 1'b1;
            end else begin
              event_left = accum;
              state      = ST_META_SKIP;
            end
          end
        end
        ST_META_SKIP: begin
          event_left = event_left - 1'b1;
          if (event_left == 0) complete = 1'b1;
        end
        ST_TEMPO: begin
          tempo = {tempo[15:0], c};
          if (tempo_count >= 2) begin
            queue_result(mfp_pkg::KIND_TEMPO, {4'd0, tempo}, mfp_pkg::ERR_NONE);
            complete = 1'b1;
          end else begin
            tempo_count++;
          end
        end
        ST_SYSEX_LEN, ST_RAW_LEN: begin
          v = take_varlen(c);
          if (v == VL_LONG) begin
            err = mfp_pkg::ERR_VARLEN;
          end else if (v == VL_DONE) begin
            status = 8'h00;
            if (state == ST_SYSEX_LEN) begin
              queue_result(mfp_pkg::KIND_MIDI, {20'd0, mfp_pkg::BYTE_SYSEX},
                           mfp_pkg::ERR_NONE);
            end
            if ({4'd0, accum} > chunk_left) begin
              err = mfp_pkg::ERR_TRUNC;
            end else if (accum == 0) begin
              complete = 1'b1;
            end else begin
              event_left = accum;
              state      = ST_FORWARD;
            end
          end
        end
        ST_FORWARD: begin
          queue_result(mfp_pkg::KIND_MIDI, {20'd0, c}, mfp_pkg::ERR_NONE);
          event_left = event_left - 1'b1;
          if (event_left == 0) complete = 1'b1;
        end
        default: begin
          state = ST_DONE;
          return;
        end
      endcase

      if (err != mfp_pkg::ERR_NONE) begin
        queue_result(mfp_pkg::KIND_ERROR, '0, err);
        state = ST_DONE;
      end else if (complete) begin
        accum    = '0;
        vl_count = '0;
        if (chunk_left == 0) begin
          queue_result(mfp_pkg::KIND_END, '0, mfp_pkg::ERR_NONE);
          state = ST_DONE;
        end else begin
          state = ST_DELTA;
        end
      end else if (state != ST_DONE && chunk_left == 0) begin
        queue_result(mfp_pkg::KIND_ERROR, '0, mfp_pkg::ERR_TRUNC);
        state = ST_DONE;
      end
      if (expected_q.size() > first) expected_q[expected_q.size() - 1].last = 1'b1;
    endfunction

    function void check_result(logic [2:0] k, logic [27:0] v, logic [2:0] e, logic l);
      parsed_result_t x;
      if (expected_q.size() == 0) begin
        $error("unexpected result: kind %0d value %0d code %0d", k, v, e);
        failures++;
        return;
      end
      x = expected_q.pop_front();
      if (k !== x.kind) begin
        $error("result_kind: expected %0d, got %0d", x.kind, k);
        failures++;
      end
      if (v !== x.value) begin
        $error("result_value: expected %0d, got %0d", x.value, v);
        failures++;
      end
      if (e !== x.err) begin
        $error("error_code: expected %0d, got %0d", x.err, e);
        failures++;
      end
      if (l !== x.last) begin
        $error("last_of_run: expected %0d, got %0d", x.last, l);
        failures++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte = 8'h00;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] track_length = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  result_kind;
  logic [27:0] result_value;
  logic [2:0]  error_code;
  logic        last_of_run;

  track_scoreboard sb = new;
  logic [7:0]      track_bytes[$];
  int              tx_idle = 0;
  int              rx_idle = 0;
  int              rx_hold = 0;

  midi_file_track_event_parser_core uut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .data_byte    (data_byte),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .track_length (track_length),
    .empty        (empty),
    .pop          (pop),
    .result_kind  (result_kind),
    .result_value (result_value),
    .error_code   (error_code),
    .last_of_run  (last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("midi_file_track_event_parser_core test failed");
    $finish;
  end

  // Result side: check accepted transactions, then pick next pop.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) sb.check_result(result_kind, result_value, error_code, last_of_run);
      if (rx_hold > 0) begin
        rx_hold--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(99) < tx_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push      <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_byte(b);
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(logic [31:0] len);
    cfg_valid    <= 1'b1;
    track_length <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.restart_track(len);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_track(logic [31:0] len, int hold);
    wait_idle();
    write_length(len);
    rx_hold = hold;
    foreach (track_bytes[i]) send_byte(track_bytes[i]);
  endtask

  function automatic void put_varlen(logic [27:0] value, int n);
    logic [7:0] b;
    for (int i = n - 1; i >= 0; i--) begin
      b = 8'((value >> (7 * i)) & 28'h7F);
      if (i != 0) b[7] = 1'b1;
      track_bytes.push_back(b);
    end
  endfunction

  function automatic void put_delta();
    int r;
    int n;
    r = $urandom_range(99);
    n = (r < 60) ? 1 : (r < 80) ? 2 : (r < 92) ? 3 : 4;
    put_varlen(28'($urandom_range(0, (1 << (7 * n)) - 1)), n);
  endfunction

  function automatic void put_blob();
    int len;
    len = $urandom_range(0, 5);
    put_varlen(28'(len), 1);
    repeat (len) track_bytes.push_back(8'($urandom_range(255)));
  endfunction

  function automatic logic [7:0] other_meta();
    logic [7:0] t;
    do t = 8'($urandom_range(255));
    while (t == mfp_pkg::META_EOT || t == mfp_pkg::META_TEMPO);
    return t;
  endfunction

  function automatic logic [31:0] build_track();
    logic [7:0] run_status;
    logic [7:0] b;
    bit         stop;
    int         r;
    int         n;
    int         size;
    track_bytes.delete();
    run_status = 8'h00;
    stop       = 1'b0;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(3, 12)) track_bytes.push_back(8'($urandom_range(255)));
      return $urandom_range(1) ? 32'($urandom) : 32'($urandom_range(1, 12));
    end
    for (int e = $urandom_range(1, 8); e > 0 && !stop; e--) begin
      r = $urandom_range(99);
      if (r >= 95) begin
        // overlong varlen in a delta or a meta length
        if ($urandom_range(1)) begin
          track_bytes.push_back(8'h00);
          track_bytes.push_back(mfp_pkg::BYTE_META);
          track_bytes.push_back(other_meta());
        end
        repeat (VARLEN_LIMIT) track_bytes.push_back(8'h80 | 8'($urandom_range(127)));
        stop = 1'b1;
        continue;
      end
      put_delta();
      if (r < 45) begin
        if (run_status == 8'h00 || $urandom_range(1)) begin
          run_status = 8'($urandom_range(8'h80, 8'hEF));
          track_bytes.push_back(run_status);
        end
        n = (run_status[6:4] == 3'd4 || run_status[6:4] == 3'd5) ? 1 : 2;
        repeat (n) begin
          track_bytes.push_back(($urandom_range(99) < 90) ? 8'($urandom_range(127))
                                                          : 8'($urandom_range(255)));
        end
      end else if (r < 55) begin
        track_bytes.push_back(mfp_pkg::BYTE_SYSEX);
        put_blob();
        run_status = 8'h00;
      end else if (r < 63) begin
        track_bytes.push_back(mfp_pkg::BYTE_RAW);
        put_blob();
        run_status = 8'h00;
      end else if (r < 75) begin
        track_bytes.push_back(mfp_pkg::BYTE_META);
        track_bytes.push_back(other_meta());
        put_blob();
        run_status = 8'h00;
      end else if (r < 85) begin
        track_bytes.push_back(mfp_pkg::BYTE_META);
        track_bytes.push_back(mfp_pkg::META_TEMPO);
        track_bytes.push_back(($urandom_range(99) < 80) ? 8'h03 : 8'($urandom_range(10)));
        repeat (3) track_bytes.push_back(8'($urandom_range(255)));
        run_status = 8'h00;
      end else if (r < 90) begin
        // length past the end of the chunk
        if ($urandom_range(1)) begin
          track_bytes.push_back(mfp_pkg::BYTE_META);
          track_bytes.push_back(other_meta());
        end else begin
          track_bytes.push_back($urandom_range(1) ? mfp_pkg::BYTE_SYSEX : mfp_pkg::BYTE_RAW);
        end
        put_varlen(28'($urandom_range(64, 28'hFFFFFFF)), 4);
        repeat ($urandom_range(0, 3)) track_bytes.push_back(8'($urandom_range(255)));
        stop = 1'b1;
      end else begin
        if ($urandom_range(1)) begin
          do b = 8'($urandom_range(8'hF1, 8'hFE)); while (b == mfp_pkg::BYTE_RAW);
        end else begin
          b = 8'($urandom_range(127));
        end
        track_bytes.push_back(b);
        stop = 1'b1;
      end
    end
    if (!stop && $urandom_range(1)) begin
      put_delta();
      track_bytes.push_back(mfp_pkg::BYTE_META);
      track_bytes.push_back(mfp_pkg::META_EOT);
      track_bytes.push_back(($urandom_range(99) < 80) ? 8'h00 : 8'($urandom_range(1, 4)));
    end
    size = track_bytes.size();
    if ($urandom_range(99) < 20) begin
      repeat ($urandom_range(1, 3)) track_bytes.push_back(8'($urandom_range(255)));
    end
    r = $urandom_range(99);
    if (r < 70 || size < 2) return 32'(size);
    if (r < 85) return 32'(size - $urandom_range(1, (size > 4) ? 4 : size - 1));
    return 32'($urandom);
  endfunction

  initial begin
    logic [31:0] len;
    int          random_count;
    tx_idle = 16;
    rx_idle = 72;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty track: everything ignored
    track_bytes = '{8'h90};
    run_track(32'd0, 0);
    // voice, running status, tempo, end of track, then an ignored byte
    track_bytes = '{8'h7F, 8'h90, 8'h3C, 8'h7F, 8'h00, 8'h40, 8'h00, 8'h00, 8'hFF,
                    8'h51, 8'h03, 8'h07, 8'hA1, 8'h20, 8'h00, 8'hFF, 8'h2F, 8'h00, 8'h55};
    run_track(32'hFFFF_FFFF, 0);
    track_bytes = '{8'h00, 8'h3C};
    run_track(32'd2, 0);
    track_bytes = '{8'h00, 8'hF1};
    run_track(32'd2, 0);
    track_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
    run_track(32'd4, 0);

    // receiver stalls while a dense voice track streams in
    tx_idle = 0;
    track_bytes.delete();
    repeat (10) begin
      track_bytes.push_back(8'h00);
      track_bytes.push_back(8'h90 | 8'($urandom_range(15)));
      track_bytes.push_back(8'($urandom_range(127)));
      track_bytes.push_back(8'($urandom_range(127)));
    end
    run_track(32'd40, 120);

    random_count = 0;
    while (random_count < 400) begin
      if (random_count < 133) begin
        tx_idle = 16;
        rx_idle = 72;
      end else if (random_count < 266) begin
        tx_idle = 72;
        rx_idle = 16;
      end else begin
        tx_idle = 0;
        rx_idle = 0;
      end
      len = build_track();
      run_track(len, 0);
      random_count += track_bytes.size();
    end

    wait_idle();
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("midi_file_track_event_parser_core test passed");
    end else begin
      $display("midi_file_track_event_parser_core test failed");
    end
    $finish;
  end

endmodule
